// ===== design/lrv_pkg.sv =====
`default_nettype none
package lrv_pkg;

  localparam int unsigned LenFieldBytes = 4;
  localparam int unsigned ChkFieldBytes = 4;
  localparam int unsigned RecHdrBytes   = LenFieldBytes + ChkFieldBytes;
  localparam logic [31:0] SeedReset     = 32'd31;
  localparam logic [31:0] ValidEndReset = 32'(ChkFieldBytes);

  typedef enum logic [2:0] {
    KindHeader  = 3'd0,
    KindLength  = 3'd1,
    KindSum     = 3'd2,
    KindPayload = 3'd3,
    KindIgnore  = 3'd4
  } byte_kind_e;

  typedef enum logic [1:0] {
    ResAccept  = 2'd0,
    ResReject  = 2'd1,
    ResSummary = 2'd2
  } result_kind_e;

  typedef struct packed {
    byte_kind_e  kind;
    logic [1:0]  idx;
    logic [7:0]  data;
    logic        eof;
    logic        hdr_done;
    logic        rec_end;
    logic        too_long;
    logic        trunc;
    logic [15:0] plen;
    logic [31:0] rec_len;
  } item_t;

  typedef struct packed {
    result_kind_e kind;
    logic [15:0]  payload_length;
    logic [31:0]  valid_end_offset;
    logic [31:0]  total_checksum;
    logic         file_ok;
    logic         last_result;
  } result_t;

  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } out_push_t;

  function automatic logic [31:0] put_le(logic [31:0] acc, logic [1:0] idx, logic [7:0] b);
    logic [31:0] r;
    r = acc;
    r[{idx, 3'b000} +: 8] = b;
    return r;
  endfunction

  function automatic logic [15:0] sat16(logic [31:0] v);
    return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/lrv_if.sv =====
`default_nettype none
interface lrv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       end_of_file;
  modport source (output valid, output file_byte, output end_of_file, input ready);
  modport sink (input valid, input file_byte, input end_of_file, output ready);
endinterface

interface lrv_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] payload_length;
  logic [31:0] valid_end_offset;
  logic [31:0] total_checksum;
  logic        file_ok;
  logic        last_result;
  modport source (output valid, output result_kind, output payload_length,
                  output valid_end_offset, output total_checksum, output file_ok,
                  output last_result, input ready);
  modport sink (input valid, input result_kind, input payload_length,
                input valid_end_offset, input total_checksum, input file_ok,
                input last_result, output ready);
endinterface

interface lrv_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_seed;
  modport source (output valid, output hash_seed, input ready);
  modport sink (input valid, input hash_seed, output ready);
endinterface
`default_nettype wire

// ===== design/lrv_fifo.sv =====
`default_nettype none
module lrv_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  ready_o,
  output logic                  valid_o,
  output logic      [Width-1:0] data_o,
  input  wire logic             pop_i
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wp_q, rp_q;
  logic [CW-1:0]    count_q;
  logic             do_push, do_pop;

  assign ready_o = count_q != CW'(Depth);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      end
      count_q <= count_q + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ===== design/lrv_front.sv =====
`default_nettype none
module lrv_front import lrv_pkg::*; #(
  parameter longint unsigned MAX_PAYLOAD_BYTES = 65535
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lrv_byte_if.sink    byte_i,
  output logic        push_o,
  output item_t       item_o,
  input  wire logic   q_ready_i
);

  localparam int unsigned PlW = $clog2(MAX_PAYLOAD_BYTES + 64'd1);
  localparam logic [32:0] LenLimit = 33'(MAX_PAYLOAD_BYTES);

  typedef enum logic [4:0] {
    PhHeader  = 5'b00001,
    PhLength  = 5'b00010,
    PhSum     = 5'b00100,
    PhPayload = 5'b01000,
    PhStop    = 5'b10000
  } phase_e;

  phase_e         phase_q, phase_d;
  logic [1:0]     cnt_q, cnt_d;
  logic [31:0]    len_q, len_d, len_new;
  logic [PlW-1:0] pay_q, pay_d, pay_inc;
  logic           fire;

  assign byte_i.ready = q_ready_i;
  assign fire         = byte_i.valid && q_ready_i;
  assign push_o       = fire;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    pay_d   = pay_q;
    len_new = put_le(len_q, cnt_q, byte_i.file_byte);
    pay_inc = pay_q + PlW'(1);

    item_o          = '0;
    item_o.kind     = KindIgnore;
    item_o.idx      = cnt_q;
    item_o.data     = byte_i.file_byte;
    item_o.eof      = byte_i.end_of_file;
    item_o.plen     = sat16(len_q);
    item_o.rec_len  = len_q;

    case (phase_q)
      PhHeader: begin
        item_o.kind = KindHeader;
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          item_o.hdr_done = 1'b1;
          phase_d = PhLength;
        end
      end
      PhLength: begin
        item_o.kind = KindLength;
        len_d = len_new;
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          if ({1'b0, len_new} > LenLimit) begin
            item_o.too_long = 1'b1;
            item_o.plen     = sat16(len_new);
            phase_d = PhStop;
          end else begin
            phase_d = PhSum;
          end
        end
      end
      PhSum: begin
        item_o.kind = KindSum;
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          pay_d = '0;
          if (len_q == '0) begin
            item_o.rec_end = 1'b1;
            phase_d = PhLength;
          end else begin
            phase_d = PhPayload;
          end
        end
      end
      PhPayload: begin
        item_o.kind = KindPayload;
        pay_d = pay_inc;
        if (pay_inc == len_q[PlW-1:0]) begin
          item_o.rec_end = 1'b1;
          phase_d = PhLength;
          len_d   = '0;
        end
      end
      PhStop: begin
        item_o.kind = KindIgnore;
      end
      default: begin
        phase_d = PhHeader;
      end
    endcase

    if (byte_i.end_of_file) begin
      if (phase_d == PhSum || phase_d == PhPayload) begin
        item_o.trunc = 1'b1;
        item_o.plen  = sat16(len_d);
      end else if (phase_d == PhLength && cnt_d != 2'd0) begin
        item_o.trunc = 1'b1;
        item_o.plen  = '0;
      end
      phase_d = PhHeader;
      cnt_d   = '0;
      len_d   = '0;
      pay_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      cnt_q   <= '0;
      len_q   <= '0;
      pay_q   <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      pay_q   <= pay_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/lrv_back.sv =====
`default_nettype none
module lrv_back import lrv_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] seed_i,
  input  wire logic        q_valid_i,
  input  wire item_t       q_item_i,
  output logic             q_pop_o,
  input  wire logic        free2_i,
  output out_push_t        push_o
);

  logic [31:0] tent_q, rh_q, tent_n, rh_n, sext, tent_mul, rh_mul;
  logic        b_valid_q;
  item_t       b_item_q;
  logic [31:0] b_tent_q, b_rh_q;
  logic        b_fire, pop;

  logic        stop_q, stop_n, hdr_q, hdr_n;
  logic [31:0] comm_q, comm_n, vend_q, vend_n, stored_q, stored_n, sum_q, sum_n;
  logic        ev;
  result_t     ev_res, sum_res;

  assign b_fire  = b_valid_q && free2_i;
  assign pop     = !b_valid_q || free2_i;
  assign q_pop_o = pop;

  always_comb begin
    sext     = {{24{q_item_i.data[7]}}, q_item_i.data};
    tent_mul = tent_q * seed_i;
    rh_mul   = rh_q * seed_i;
    tent_n   = tent_q;
    rh_n     = rh_q;
    if (q_item_i.kind == KindLength || q_item_i.kind == KindSum ||
        q_item_i.kind == KindPayload) begin
      tent_n = tent_mul + sext;
    end
    if (q_item_i.kind == KindPayload) begin
      rh_n = rh_mul + sext;
    end else if (q_item_i.kind == KindSum && q_item_i.idx == 2'd3) begin
      rh_n = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && q_valid_i) begin
      b_item_q <= q_item_i;
      b_tent_q <= tent_n;
      b_rh_q   <= rh_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      tent_q    <= '0;
      rh_q      <= '0;
    end else if (pop) begin
      b_valid_q <= q_valid_i;
      if (q_valid_i) begin
        tent_q <= q_item_i.eof ? '0 : tent_n;
        rh_q   <= q_item_i.eof ? '0 : rh_n;
      end
    end
  end

  always_comb begin
    stored_n = (b_item_q.kind == KindHeader) ?
               put_le(stored_q, b_item_q.idx, b_item_q.data) : stored_q;
    sum_n    = (b_item_q.kind == KindSum) ?
               put_le(sum_q, b_item_q.idx, b_item_q.data) : sum_q;
    hdr_n    = hdr_q | b_item_q.hdr_done;
    stop_n   = stop_q;
    comm_n   = comm_q;
    vend_n   = vend_q;
    ev       = 1'b0;
    ev_res   = '0;
    ev_res.kind           = ResReject;
    ev_res.payload_length = b_item_q.plen;

    if (!stop_q) begin
      if (b_item_q.too_long) begin
        ev     = 1'b1;
        stop_n = 1'b1;
      end else if (b_item_q.rec_end) begin
        ev = 1'b1;
        if (b_rh_q == sum_n) begin
          comm_n      = b_tent_q;
          vend_n      = vend_q + 32'(RecHdrBytes) + b_item_q.rec_len;
          ev_res.kind = ResAccept;
        end else begin
          stop_n = 1'b1;
        end
      end
    end
    if (b_item_q.eof && !stop_n && b_item_q.trunc) begin
      ev     = 1'b1;
      stop_n = 1'b1;
    end
    ev_res.valid_end_offset = vend_n;
    ev_res.total_checksum   = comm_n;
    ev_res.file_ok          = 1'b0;
    ev_res.last_result      = !b_item_q.eof;

    sum_res                  = '0;
    sum_res.kind             = ResSummary;
    sum_res.valid_end_offset = vend_n;
    sum_res.total_checksum   = comm_n;
    sum_res.file_ok          = hdr_n && (comm_n == stored_n);
    sum_res.last_result      = 1'b1;

    push_o       = '0;
    push_o.res0  = ev ? ev_res : sum_res;
    push_o.res1  = sum_res;
    push_o.push0 = b_fire && (ev || b_item_q.eof);
    push_o.push1 = b_fire && ev && b_item_q.eof;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q   <= 1'b0;
      hdr_q    <= 1'b0;
      comm_q   <= '0;
      vend_q   <= ValidEndReset;
      stored_q <= '0;
      sum_q    <= '0;
    end else if (b_fire) begin
      if (b_item_q.eof) begin
        stop_q   <= 1'b0;
        hdr_q    <= 1'b0;
        comm_q   <= '0;
        vend_q   <= ValidEndReset;
        stored_q <= '0;
        sum_q    <= '0;
      end else begin
        stop_q   <= stop_n;
        hdr_q    <= hdr_n;
        comm_q   <= comm_n;
        vend_q   <= vend_n;
        stored_q <= stored_n;
        sum_q    <= sum_n;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/lrv_outq.sv =====
`default_nettype none
module lrv_outq import lrv_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire out_push_t push_i,
  output logic           free2_o,
  lrv_result_if.source result_o
);

  result_t    mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] count_q;
  logic       do_pop;
  result_t    head;

  assign head    = mem_q[rp_q];
  assign free2_o = count_q <= 3'd2;
  assign do_pop  = result_o.valid && result_o.ready;

  assign result_o.valid            = count_q != 3'd0;
  assign result_o.result_kind      = head.kind;
  assign result_o.payload_length   = head.payload_length;
  assign result_o.valid_end_offset = head.valid_end_offset;
  assign result_o.total_checksum   = head.total_checksum;
  assign result_o.file_ok          = head.file_ok;
  assign result_o.last_result      = head.last_result;

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wp_q] <= push_i.res0;
    end
    if (push_i.push1) begin
      mem_q[wp_q + 2'd1] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_q + 2'(push_i.push0) + 2'(push_i.push1);
      rp_q    <= rp_q + 2'(do_pop);
      count_q <= count_q + 3'(push_i.push0) + 3'(push_i.push1) - 3'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ===== design/log_record_verifier.sv =====
`default_nettype none
// Write-ahead log checker. Takes one file byte per beat and sustains one byte per clock
// cycle unless the result queue stalls it; that figure is set by the running hashes,
// each a 32x32 multiply-add that updates once per byte. A parser classifies bytes as
// header, length, checksum or payload and places them in a four-entry queue; a hash
// stage and a decision stage follow. A result comes at the end of each record (accept
// or reject) until one is rejected, and on the end-of-file byte (an optional truncation
// reject, then the summary); one byte causes at most two. A four-entry result queue
// lets the input keep flowing while results wait. The hash seed may be written only
// while the block is idle.
module log_record_verifier import lrv_pkg::*; #(
  parameter longint unsigned MAX_PAYLOAD_BYTES = 65535
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  lrv_byte_if.sink      byte_i,
  lrv_result_if.source  result_o,
  lrv_cfg_if.sink       cfg_i
);

  logic [31:0] seed_q;
  logic        f_push, q_ready, q_valid, q_pop, free2;
  item_t       f_item, q_item;
  out_push_t   b_push;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedReset;
    end else if (cfg_i.valid) begin
      seed_q <= cfg_i.hash_seed;
    end
  end

  lrv_front #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_i),
    .push_o    (f_push),
    .item_o    (f_item),
    .q_ready_i (q_ready)
  );

  lrv_fifo #(
    .Width($bits(item_t)),
    .Depth(4)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (q_item),
    .pop_i   (q_pop)
  );

  lrv_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seed_i    (seed_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .free2_i   (free2),
    .push_o    (b_push)
  );

  lrv_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (b_push),
    .free2_o  (free2),
    .result_o (result_o)
  );

endmodule
`default_nettype wire

// ===== test/log_record_verifier_test.sv =====
`timescale 1ns / 1ps
module log_record_verifier_test import lrv_pkg::*;;

  localparam int unsigned CycleLimit = 200_000;
  localparam logic [31:0] MaxPayload = 32'd65535;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #10 clk_i = ~clk_i;

  lrv_byte_if   byte_if ();
  lrv_result_if result_if ();
  lrv_cfg_if    cfg_if ();

  log_record_verifier u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  logic [31:0] seed_model;
  byte_kind_e  scan_phase;
  logic [31:0] field_count;
  logic [31:0] record_length;
  logic [31:0] stored_record_sum;
  logic [31:0] record_hash;
  logic [31:0] committed_total;
  logic [31:0] tentative_total;
  logic [31:0] stored_file_total;
  logic [31:0] valid_end;
  logic [31:0] payload_seen;
  logic        header_done;

  result_t     expected_results[$];
  logic [7:0]  log_image[$];

  bit          byte_idle = 1'b1;
  bit          result_idle = 1'b1;
  int unsigned failures = 0;
  int unsigned bytes_sent = 0;
  int unsigned files_sent = 0;
  int unsigned results_seen = 0;
  int unsigned seeds_used = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;

  function automatic logic [31:0] rolling_hash(logic [31:0] h, logic [7:0] b);
    logic [31:0] product;
    product = h * seed_model;
    return product + {{24{b[7]}}, b};
  endfunction

  function automatic void push_result(result_kind_e kind, logic [31:0] plen, logic ok);
    result_t r;
    r.kind             = kind;
    r.payload_length   = (plen > MaxPayload) ? 16'hFFFF : plen[15:0];
    r.valid_end_offset = valid_end;
    r.total_checksum   = committed_total;
    r.file_ok          = ok;
    r.last_result      = 1'b0;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void reject_record(logic [31:0] plen);
    push_result(ResReject, plen, 1'b0);
    scan_phase = KindIgnore;
  endfunction

  function automatic void close_record();
    if (record_hash == stored_record_sum) begin
      committed_total   = tentative_total;
      valid_end         = valid_end + 32'(RecHdrBytes) + record_length;
      push_result(ResAccept, record_length, 1'b0);
      scan_phase        = KindLength;
      field_count       = 0;
      record_length     = 0;
      stored_record_sum = 0;
    end else begin
      reject_record(record_length);
    end
  endfunction

  function automatic void clear_scan();
    scan_phase        = KindHeader;
    field_count       = 0;
    record_length     = 0;
    stored_record_sum = 0;
    record_hash       = 0;
    committed_total   = 0;
    tentative_total   = 0;
    stored_file_total = 0;
    valid_end         = 32'(ChkFieldBytes);
    payload_seen      = 0;
    header_done       = 1'b0;
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic eof);
    int unsigned first;
    first = expected_results.size();
    case (scan_phase)
      KindHeader: begin
        stored_file_total |= 32'(b) << (8 * field_count[1:0]);
        field_count++;
        if (field_count >= ChkFieldBytes) begin
          field_count     = 0;
          header_done     = 1'b1;
          tentative_total = committed_total;
          scan_phase      = KindLength;
        end
      end
      KindLength: begin
        tentative_total = rolling_hash(tentative_total, b);
        record_length |= 32'(b) << (8 * field_count[1:0]);
        field_count++;
        if (field_count >= LenFieldBytes) begin
          field_count = 0;
          if (record_length > MaxPayload) reject_record(record_length);
          else scan_phase = KindSum;
        end
      end
      KindSum: begin
        tentative_total = rolling_hash(tentative_total, b);
        stored_record_sum |= 32'(b) << (8 * field_count[1:0]);
        field_count++;
        if (field_count >= ChkFieldBytes) begin
          field_count  = 0;
          record_hash  = 0;
          payload_seen = 0;
          if (record_length == 0) close_record();
          else scan_phase = KindPayload;
        end
      end
      KindPayload: begin
        tentative_total = rolling_hash(tentative_total, b);
        record_hash     = rolling_hash(record_hash, b);
        payload_seen++;
        if (payload_seen >= record_length) close_record();
      end
      default: begin
      end
    endcase
    if (eof) begin
      if (scan_phase == KindSum || scan_phase == KindPayload) reject_record(record_length);
      else if (scan_phase == KindLength && field_count != 0) reject_record('0);
      push_result(ResSummary, '0, header_done && committed_total == stored_file_total);
      clear_scan();
    end
    if (expected_results.size() > first)
      expected_results[expected_results.size() - 1].last_result = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none, actual kind %0d", $time,
                 result_if.result_kind);
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", want.kind, result_if.result_kind);
        check_field("payload_length", want.payload_length, result_if.payload_length);
        check_field("valid_end_offset", want.valid_end_offset, result_if.valid_end_offset);
        check_field("total_checksum", want.total_checksum, result_if.total_checksum);
        check_field("file_ok", want.file_ok, result_if.file_ok);
        check_field("last_result", want.last_result, result_if.last_result);
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      result_if.ready <= 1'b0;
    end else if (result_idle && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 5);
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.", cycle_count,
               expected_results.size());
      $display("log_record_verifier_test: FAIL");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic eof);
    if (byte_idle && $urandom_range(0, 4) == 0) begin
      byte_if.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    byte_if.valid       = 1'b1;
    byte_if.file_byte   = b;
    byte_if.end_of_file = eof;
    do @(posedge clk_i); while (!byte_if.ready);
    bytes_sent++;
    predict_byte(b, eof);
    @(negedge clk_i);
  endtask

  // Bytes that close no record leave work in flight, so a margin follows the drain.
  task automatic wait_idle();
    byte_if.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_seed(logic [31:0] seed);
    wait_idle();
    cfg_if.valid     = 1'b1;
    cfg_if.hash_seed = seed;
    do @(posedge clk_i); while (!cfg_if.ready);
    seed_model = seed;
    seeds_used++;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  function automatic void put_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) log_image.insert(log_image.size(), w[8*i +: 8]);
  endfunction

  function automatic void add_record(logic [31:0] len, bit corrupt);
    logic [7:0]  payload[$];
    logic [31:0] sum;
    sum = 0;
    for (int unsigned i = 0; i < len; i++) begin
      payload.insert(payload.size(), 8'($urandom));
      sum = rolling_hash(sum, payload[$]);
    end
    if (corrupt) sum ^= 32'd1 << $urandom_range(0, 31);
    put_word(len);
    put_word(sum);
    foreach (payload[i]) log_image.insert(log_image.size(), payload[i]);
  endfunction

  // Prepends the file header and sends the first keep bytes, zero meaning all of them.
  task automatic send_image(bit good_total, int unsigned keep);
    logic [31:0] total;
    total = 0;
    foreach (log_image[i]) total = rolling_hash(total, log_image[i]);
    if (!good_total) total = $urandom;
    for (int i = 3; i >= 0; i--) log_image.push_front(total[8*i +: 8]);
    if (keep == 0 || keep > log_image.size()) keep = log_image.size();
    for (int unsigned i = 0; i < keep; i++) send_byte(log_image[i], i == keep - 1);
    log_image.delete();
    files_sent++;
  endtask

  task automatic test_header_edges();
    send_image(1'b1, 0);
    send_image(1'b1, 2);
    send_image(1'b0, 0);
  endtask

  task automatic test_empty_records();
    add_record(0, 1'b0);
    send_image(1'b1, 0);
    add_record(2, 1'b0);
    add_record(0, 1'b1);
    send_image(1'b1, 0);
  endtask

  task automatic test_overlong_records();
    put_word(32'd65536);
    send_image(1'b1, 0);
    put_word(32'hFFFF_FFFF);
    add_record(2, 1'b0);
    send_image(1'b1, 0);
  endtask

  task automatic test_truncation();
    add_record(5, 1'b0);
    send_image(1'b1, 6);
    add_record(5, 1'b0);
    send_image(1'b1, 10);
    add_record(5, 1'b0);
    send_image(1'b1, 15);
  endtask

  task automatic test_bad_checksum();
    add_record(3, 1'b0);
    add_record(4, 1'b1);
    add_record(2, 1'b0);
    send_image(1'b1, 0);
  endtask

  task automatic test_seed_extremes();
    logic [31:0] seeds[4];
    seeds = '{32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1};
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      add_record(3, 1'b0);
      add_record(0, 1'b0);
      send_image(1'b1, 0);
    end
  endtask

  task automatic test_random_files();
    int unsigned begin_bytes;
    int unsigned pick;
    int unsigned nrec;
    int unsigned kind;
    begin_bytes = bytes_sent;
    while (bytes_sent - begin_bytes < 170) begin
      if (bytes_sent - begin_bytes > 120) begin
        byte_idle   = 1'b0;
        result_idle = 1'b0;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) write_seed($urandom);
      if (pick == 1) begin
        repeat ($urandom_range(1, 24)) log_image.insert(log_image.size(), 8'($urandom));
        send_image($urandom_range(0, 1), 0);
      end else begin
        nrec = $urandom_range(0, 4);
        for (int unsigned i = 0; i < nrec; i++) begin
          kind = $urandom_range(0, 19);
          if (kind == 0) begin
            put_word($urandom_range(32'hFFFF_FFFF, 32'd65536));
            break;
          end
          if (kind == 1) add_record($urandom_range(13, 300), 1'b0);
          else add_record($urandom_range(0, 12), kind == 2);
        end
        if ($urandom_range(0, 5) == 0) send_image(1'b1, $urandom_range(1, log_image.size() + 4));
        else send_image($urandom_range(0, 3) != 0, 0);
      end
    end
  endtask

  initial begin
    byte_if.valid       = 1'b0;
    byte_if.file_byte   = '0;
    byte_if.end_of_file = 1'b0;
    result_if.ready     = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.hash_seed    = '0;
    seed_model          = SeedReset;
    clear_scan();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_header_edges();
    test_empty_records();
    test_overlong_records();
    test_truncation();
    test_bad_checksum();
    test_seed_extremes();
    test_random_files();
    wait_idle();

    $display("Sent %0d log bytes in %0d files under %0d seed writes.", bytes_sent,
             files_sent, seeds_used);
    $display("Checked %0d results against the prediction.", results_seen);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("log_record_verifier_test: PASS");
    end else begin
      $display("log_record_verifier_test: FAIL");
    end
    $finish;
  end

endmodule
